// ----- rtl/gapt_pkg.sv -----
package gapt_pkg;

    // Field and storage widths
    localparam int WORD_W      = 64;
    localparam int IDX_W       = 10;
    localparam int MAX_WORDS   = 1024;
    localparam int MAX_ROWS    = 256;
    localparam int GENOTYPES   = 3;
    localparam int GT_W        = 2;
    localparam int ROW_W       = 8;
    localparam int CNT_W       = 17;
    localparam int WORDS_REG_W = 11;
    localparam int ROWS_REG_W  = 9;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int PC_W        = 7;
    localparam int BYTES       = WORD_W / 8;

    // Stream bus widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // Result queue, in whole rows
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_W-1:0] ACC_MAX = '1;

    typedef enum logic {
        OP_STORE  = 1'b0,
        OP_STREAM = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORDS = 1'b0,
        REG_ROWS  = 1'b1
    } reg_idx_t;

    typedef logic [CNT_W-1:0] count_t;

    // Three finished counts of one first-table row
    typedef struct packed {
        logic [ROW_W-1:0]              row;
        count_t [GENOTYPES-1:0]        counts;
    } row_result_t;

    // Per-byte population count, SWAR style
    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        begin
            a = v - ((v >> 1) & 8'h55);
            b = (a & 8'h33) + ((a >> 2) & 8'h33);
            c = (b + (b >> 4)) & 8'h0F;
            pop8 = c[3:0];
        end
    endfunction

endpackage

// ----- rtl/gapt_ram.sv -----
module gapt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Simple dual port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/gapt_count.sv -----
module gapt_count (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    clear,
    input  logic [gapt_pkg::ROWS_REG_W-1:0]         rows_in_use,
    input  logic                                    a_valid,
    input  logic                                    a_last,
    input  logic [gapt_pkg::WORD_W-1:0]             a_data,
    input  logic [gapt_pkg::GENOTYPES-1:0][gapt_pkg::WORD_W-1:0] stored_words,
    output logic                                    b_pending,
    output logic                                    push,
    output gapt_pkg::row_result_t                   result
);
    import gapt_pkg::*;

    logic                                  b_valid_reg;
    logic                                  b_last_reg;
    logic [GENOTYPES-1:0][BYTES-1:0][3:0]  b_pop_reg;
    logic [GENOTYPES-1:0][BYTES-1:0][3:0]  b_pop_next;

    count_t [GENOTYPES-1:0]  acc_reg;
    count_t [GENOTYPES-1:0]  acc_sum;
    logic [ROW_W-1:0]        row_reg;
    logic [ROW_W-1:0]        row_next;
    logic [ROWS_REG_W-1:0]   row_inc;

    // AND with stored rows, byte popcounts
    always_comb begin
        for (int g = 0; g < GENOTYPES; g++) begin
            for (int k = 0; k < BYTES; k++) begin
                b_pop_next[g][k] = pop8(a_data[8*k +: 8] & stored_words[g][8*k +: 8]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
        end else begin
            b_valid_reg <= a_valid;
            b_last_reg  <= a_valid & a_last;
        end
        b_pop_reg <= b_pop_next;
    end

    // Word total and saturating accumulate
    always_comb begin
        logic [PC_W-1:0]  word_pop;
        logic [CNT_W:0]   wide;
        for (int g = 0; g < GENOTYPES; g++) begin
            word_pop = '0;
            for (int k = 0; k < BYTES; k++) begin
                word_pop = word_pop + PC_W'(b_pop_reg[g][k]);
            end
            wide = {1'b0, acc_reg[g]} + (CNT_W + 1)'(word_pop);
            acc_sum[g] = wide[CNT_W] ? ACC_MAX : wide[CNT_W-1:0];
        end
    end

    // Row counter wraps after the last row
    assign row_inc  = {1'b0, row_reg} + ROWS_REG_W'(1);
    assign row_next = (row_inc >= rows_in_use) ? '0 : row_inc[ROW_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            acc_reg <= '0;
            row_reg <= '0;
        end else if (b_valid_reg) begin
            if (b_last_reg) begin
                acc_reg <= '0;
                row_reg <= row_next;
            end else begin
                acc_reg <= acc_sum;
            end
        end
    end

    assign b_pending     = b_valid_reg & b_last_reg;
    assign push          = b_valid_reg & b_last_reg;
    assign result.row    = row_reg;
    assign result.counts = acc_sum;

endmodule

// ----- rtl/gapt_out.sv -----
module gapt_out (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 push,
    input  gapt_pkg::row_result_t                result,
    output logic [gapt_pkg::FIFO_CNT_W-1:0]      fill,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [gapt_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [gapt_pkg::M_TUSER_W-1:0]       m_tuser,
    output logic                                 m_tlast
);
    import gapt_pkg::*;

    row_result_t             queue [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   fill_reg;
    logic [GT_W-1:0]         col_reg;
    logic                    xfer;
    logic                    pop;
    row_result_t             head;
    count_t                  head_count;

    assign xfer = m_tvalid & m_tready;
    assign pop  = xfer & (col_reg == GT_W'(GENOTYPES - 1));

    // Row queue
    always_ff @(posedge aclk) begin
        if (push) begin
            queue[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            col_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            fill_reg <= fill_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
            // One transfer per genotype column
            if (pop) begin
                col_reg <= '0;
            end else if (xfer) begin
                col_reg <= col_reg + GT_W'(1);
            end
        end
    end

    assign head = queue[rd_ptr_reg];

    always_comb begin
        case (col_reg)
            2'd0:    head_count = head.counts[0];
            2'd1:    head_count = head.counts[1];
            default: head_count = head.counts[2];
        endcase
    end

    assign fill     = fill_reg;
    assign m_tvalid = (fill_reg != '0);
    assign m_tdata  = {{(M_TDATA_W - ROW_W - CNT_W){1'b0}}, head_count, head.row};
    assign m_tuser  = col_reg;
    assign m_tlast  = (col_reg == GT_W'(GENOTYPES - 1));

endmodule

// ----- rtl/genotype_and_popcount_table.sv -----
// Contingency-table builder: popcounts of bit-packed genotype rows ANDed together.
// Input stream (s_): tuser[0] selects a store (0) or a stream word (1); a store
// writes data_word into second-table row tuser[2:1] at word_index. Stream words
// are ANDed with the three stored words at the same index and counted per column.
// Output stream (m_): three transfers per finished first-table row, columns 0..2,
// tlast on the third. Config port: cfg_we/cfg_index/cfg_wdata set words per row
// and row count; a write also restarts the table. Write only while idle.
// Throughput: one input transfer per cycle. The output drains three transfers per
// row, so rows shorter than three words fill the row queue and then stall the input.
// A row's first count passes the RAM read, the byte popcount stage and the accumulate
// into the row queue after the transfer of its last word, and can then transfer.
// The row queue holds four rows; s_tready falls once queued and in-flight rows
// would fill it, so a stalled receiver backs up into the input without loss.
// Reset clears accumulators, row counter and queue and sets both registers to 1;
// the second-table RAMs are not cleared and hold no data until written.
module genotype_and_popcount_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration
    input  logic                                cfg_we,
    input  logic [gapt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gapt_pkg::CFG_W-1:0]          cfg_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gapt_pkg::S_TDATA_W-1:0]      s_tdata,   // word_index, data_word, pad
    input  logic [gapt_pkg::S_TUSER_W-1:0]      s_tuser,   // operation, genotype
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gapt_pkg::M_TDATA_W-1:0]      m_tdata,   // row_index, cell_count, pad
    output logic [gapt_pkg::M_TUSER_W-1:0]      m_tuser,   // genotype_column
    output logic                                m_tlast
);
    import gapt_pkg::*;

    logic [WORDS_REG_W-1:0]  words_reg;
    logic [ROWS_REG_W-1:0]   rows_reg;
    logic [WORDS_REG_W-1:0]  words_next;
    logic [ROWS_REG_W-1:0]   rows_next;

    logic                    accept;
    op_t                     op;
    logic [GT_W-1:0]         gt;
    logic [IDX_W-1:0]        widx;
    logic [WORD_W-1:0]       dword;
    logic                    in_range;

    logic                    a_valid_reg;
    logic                    a_last_reg;
    logic [WORD_W-1:0]       a_data_reg;

    logic [GENOTYPES-1:0][WORD_W-1:0] stored_words;
    logic                    b_pending;
    logic                    push;
    row_result_t             result;
    logic [FIFO_CNT_W-1:0]   fill;
    logic [FIFO_CNT_W+1:0]   committed;

    // Field unpacking
    assign op    = op_t'(s_tuser[0]);
    assign gt    = s_tuser[GT_W:1];
    assign widx  = s_tdata[IDX_W-1:0];
    assign dword = s_tdata[IDX_W +: WORD_W];

    assign accept   = s_tvalid & s_tready;
    assign in_range = ({1'b0, widx} < words_reg);

    // Register writes, clamped to 1..max
    always_comb begin
        words_next = cfg_wdata[WORDS_REG_W-1:0];
        if (words_next == '0) begin
            words_next = WORDS_REG_W'(1);
        end else if (words_next > WORDS_REG_W'(MAX_WORDS)) begin
            words_next = WORDS_REG_W'(MAX_WORDS);
        end
        rows_next = cfg_wdata[ROWS_REG_W-1:0];
        if (rows_next == '0) begin
            rows_next = ROWS_REG_W'(1);
        end else if (rows_next > ROWS_REG_W'(MAX_ROWS)) begin
            rows_next = ROWS_REG_W'(MAX_ROWS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg <= WORDS_REG_W'(1);
            rows_reg  <= ROWS_REG_W'(1);
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_WORDS: words_reg <= words_next;
                REG_ROWS:  rows_reg  <= rows_next;
                default:   ;
            endcase
        end
    end

    // Second-table rows, one RAM per genotype
    for (genvar g = 0; g < GENOTYPES; g++) begin : g_row
        gapt_ram #(
            .DEPTH (MAX_WORDS),
            .WIDTH (WORD_W)
        ) u_ram (
            .aclk  (aclk),
            .we    (accept && op == OP_STORE && gt == GT_W'(g)),
            .waddr (widx),
            .wdata (dword),
            .raddr (widx),
            .rdata (stored_words[g])
        );
    end

    // Read stage: stream word waits for the RAM data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
        end else begin
            a_valid_reg <= accept && op == OP_STREAM && in_range;
            a_last_reg  <= ({1'b0, widx} == words_reg - WORDS_REG_W'(1));
        end
        a_data_reg <= dword;
    end

    gapt_count u_count (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clear        (cfg_we),
        .rows_in_use  (rows_reg),
        .a_valid      (a_valid_reg),
        .a_last       (a_last_reg),
        .a_data       (a_data_reg),
        .stored_words (stored_words),
        .b_pending    (b_pending),
        .push         (push),
        .result       (result)
    );

    gapt_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .result   (result),
        .fill     (fill),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Credit check: queued rows plus rows still in the pipe
    assign committed = (FIFO_CNT_W + 2)'(fill)
                     + (FIFO_CNT_W + 2)'(a_valid_reg & a_last_reg)
                     + (FIFO_CNT_W + 2)'(b_pending);
    assign s_tready  = (committed < (FIFO_CNT_W + 2)'(FIFO_DEPTH));

endmodule
